// ===== rtl/rc_serial_frame_decoder_unit_assert.svh =====
// assertion macros used by the checker file
`ifndef RC_SERIAL_FRAME_DECODER_UNIT_ASSERT_SVH
`define RC_SERIAL_FRAME_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while rst_n is low
`define RCSFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rcsfd assertion failed");

// next-cycle implication, disabled while rst_n is low
`define RCSFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rcsfd assertion failed");

`endif

// ===== rtl/rcsfd_pkg.sv =====
// package: constants and types for the serial frame decoder
`timescale 1ns / 1ps

package rcsfd_pkg;

    localparam logic [7:0] HDR_BYTE   = 8'h0F;
    localparam logic [7:0] FTR_BYTE   = 8'h00;
    localparam int         DATA_LEN   = 22;
    localparam int         FRAME_LEN  = 25;
    localparam int         DATA_W     = DATA_LEN * 8;
    localparam int         RAW_W      = 11;
    localparam int         NUM_CH     = 16;
    localparam int         IDX_W      = 4;
    localparam int         POS_W      = 5;
    localparam int         PROD_W     = 27;
    localparam int         FRAC_W     = 12;
    localparam int         VAL_W      = 18;
    localparam int         CFG_W      = 16;
    localparam int         FIFO_DEPTH = 2;

    localparam logic [POS_W-1:0] POS_HUNT   = '0;
    localparam logic [POS_W-1:0] POS_LAST_D = POS_W'(DATA_LEN);
    localparam logic [POS_W-1:0] POS_FOOTER = POS_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] LAST_CH    = IDX_W'(NUM_CH - 1);

    localparam logic [CFG_W-1:0] SCALE_FACTOR_RST = 16'd2560;
    localparam logic [CFG_W-1:0] SCALE_OFFSET_RST = 16'd880;

    typedef enum logic [0:0] {
        REG_SCALE_FACTOR = 1'b0,
        REG_SCALE_OFFSET = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic        [CFG_W-1:0] scale_factor;
        logic signed [CFG_W-1:0] scale_offset;
    } t_cfg;

    typedef logic [DATA_W-1:0] t_frame;

endpackage

// ===== rtl/rcsfd_front.sv =====
// front end: header hunt, frame byte capture and footer check
`timescale 1ns / 1ps

module rcsfd_front
    import rcsfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_frame     o_q_data
);

    logic [POS_W-1:0] r_pos, n_pos;
    t_frame           r_shift;
    logic             w_acc;

    // only the footer byte needs room in the queue
    assign o_rx_ready = !((r_pos == POS_FOOTER) && i_q_full);
    assign w_acc      = i_rx_valid && o_rx_ready;
    assign o_q_push   = w_acc && (r_pos == POS_FOOTER) && (i_rx_byte == FTR_BYTE);
    assign o_q_data   = r_shift;

    always_comb begin
        n_pos = r_pos;
        if (w_acc) begin
            if (r_pos == POS_HUNT) begin
                if (i_rx_byte == HDR_BYTE) begin
                    n_pos = POS_W'(1);
                end
            end else if (r_pos == POS_FOOTER) begin
                n_pos = POS_HUNT;
            end else begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
        end else begin
            r_pos <= n_pos;
        end
    end

    // byte 1 ends up in the low bits, so channel c sits at bit 11*c
    always_ff @(posedge i_clk) begin
        if (w_acc && (r_pos != POS_HUNT) && (r_pos <= POS_LAST_D)) begin
            r_shift <= {i_rx_byte, r_shift[DATA_W-1:8]};
        end
    end

endmodule

// ===== rtl/rcsfd_fifo.sv =====
// short queue of captured frames between front and back end
`timescale 1ns / 1ps

module rcsfd_fifo
    import rcsfd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_nempty,
    output t_frame o_data
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_frame           r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign o_full   = (r_cnt == CNT_W'(FIFO_DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_data   = r_mem[r_rd];
    assign w_push   = i_push && !o_full;
    assign w_pop    = i_pop && o_nempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(w_push) - CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/rcsfd_back.sv =====
// back end: channel unpack, scaling pipeline and output register
`timescale 1ns / 1ps

module rcsfd_back
    import rcsfd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_q_nempty,
    input  t_frame                  i_q_data,
    output logic                    o_q_pop,
    output logic                    o_ch_valid,
    input  logic                    i_ch_ready,
    output logic [IDX_W-1:0]        o_channel_index,
    output logic signed [VAL_W-1:0] o_channel_value,
    output logic                    o_last_channel
);

    logic                    r_busy;
    logic [IDX_W-1:0]        r_ch;
    t_frame                  r_bits;
    logic                    r_p_valid;
    logic [IDX_W-1:0]        r_p_idx;
    logic [PROD_W-1:0]       r_prod;
    logic                    r_o_valid;
    logic [IDX_W-1:0]        r_o_idx;
    logic signed [VAL_W-1:0] r_o_val;
    logic                    r_o_last;

    logic                    w_en;
    logic [PROD_W-1:0]       w_prod;
    logic [PROD_W-1:0]       w_round;
    logic [VAL_W-1:0]        w_scaled;
    logic signed [VAL_W-1:0] w_sum;

    assign w_en     = !r_o_valid || i_ch_ready;
    assign o_q_pop  = !r_busy && i_q_nempty;
    assign w_prod   = PROD_W'(r_bits[RAW_W-1:0]) * PROD_W'(i_cfg.scale_factor);
    // round half up, then keep what fits below the product width
    assign w_round  = r_prod + PROD_W'(1 << (FRAC_W - 1));
    assign w_scaled = VAL_W'(w_round[PROD_W-1:FRAC_W]);
    assign w_sum    = $signed(w_scaled) + VAL_W'(i_cfg.scale_offset);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_ch      <= '0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_ch   <= '0;
            end else if (w_en && r_busy) begin
                r_ch <= r_ch + IDX_W'(1);
                if (r_ch == LAST_CH) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_en) begin
                r_p_valid <= r_busy;
                r_o_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_bits <= i_q_data;
        end else if (w_en && r_busy) begin
            r_bits <= r_bits >> RAW_W;
        end
        if (w_en) begin
            r_prod   <= w_prod;
            r_p_idx  <= r_ch;
            r_o_idx  <= r_p_idx;
            r_o_val  <= w_sum;
            r_o_last <= (r_p_idx == LAST_CH);
        end
    end

    assign o_ch_valid      = r_o_valid;
    assign o_channel_index = r_o_idx;
    assign o_channel_value = r_o_val;
    assign o_last_channel  = r_o_last;

endmodule

// ===== rtl/rc_serial_frame_decoder_unit.sv =====
// top level of the sixteen-channel serial frame decoder
//
//   port group   direction  handshake             payload
//   rx           in         i_rx_valid/o_rx_ready i_rx_byte
//   ch           out        o_ch_valid/i_ch_ready o_channel_index, o_channel_value,
//                                                 o_last_channel
//   cfg          in         i_cfg_we              i_cfg_idx, i_cfg_data
//
// one byte is taken per cycle; a frame is 25 bytes from header to footer
// a good footer queues the frame; the sixteen results follow from the
// back end one per cycle while i_ch_ready is high, through the product and output registers
// the two-entry frame queue lets emission overlap the next frame's bytes;
// o_rx_ready drops only on a footer byte while the queue is full
// reset is synchronous and needs no clearing pass
`timescale 1ns / 1ps

module rc_serial_frame_decoder_unit
    import rcsfd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_rx_valid,
    output logic                    o_rx_ready,
    input  logic [7:0]              i_rx_byte,
    input  logic                    i_cfg_we,
    input  logic [0:0]              i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data,
    output logic                    o_ch_valid,
    input  logic                    i_ch_ready,
    output logic [IDX_W-1:0]        o_channel_index,
    output logic signed [VAL_W-1:0] o_channel_value,
    output logic                    o_last_channel
);

    t_cfg   r_cfg;
    logic   w_push, w_full, w_pop, w_nempty;
    t_frame w_wdata, w_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_factor <= SCALE_FACTOR_RST;
            r_cfg.scale_offset <= SCALE_OFFSET_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_SCALE_FACTOR: r_cfg.scale_factor <= i_cfg_data;
                REG_SCALE_OFFSET: r_cfg.scale_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rcsfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (w_full),
        .o_q_push   (w_push),
        .o_q_data   (w_wdata)
    );

    rcsfd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_wdata),
        .o_full   (w_full),
        .i_pop    (w_pop),
        .o_nempty (w_nempty),
        .o_data   (w_rdata)
    );

    rcsfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_nempty      (w_nempty),
        .i_q_data        (w_rdata),
        .o_q_pop         (w_pop),
        .o_ch_valid      (o_ch_valid),
        .i_ch_ready      (i_ch_ready),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_last_channel  (o_last_channel)
    );

endmodule

// ===== rtl/rcsfd_checker.sv =====
// port-level checker for the frame decoder, bound to the top level
`timescale 1ns / 1ps
`include "rc_serial_frame_decoder_unit_assert.svh"

module rcsfd_checker
    import rcsfd_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_rx_valid,
    input logic                    o_rx_ready,
    input logic [7:0]              i_rx_byte,
    input logic                    o_ch_valid,
    input logic                    i_ch_ready,
    input logic [IDX_W-1:0]        o_channel_index,
    input logic signed [VAL_W-1:0] o_channel_value,
    input logic                    o_last_channel
);

    // a byte held off by the block stays put until taken
    `RCSFD_ASSERT_NXT(a_in_hold, i_clk, i_rst_n, i_rx_valid && !o_rx_ready, i_rx_valid && $stable(i_rx_byte))

    // a stalled result holds its payload
    `RCSFD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_ch_valid && !i_ch_ready, o_ch_valid && $stable(o_channel_index) && $stable(o_channel_value) && $stable(o_last_channel))

    // last mark goes with channel fifteen only
    `RCSFD_ASSERT_IMP(a_last_idx, i_clk, i_rst_n, o_ch_valid, o_last_channel == (o_channel_index == LAST_CH))

    // a result that is not the last is followed by its successor channel
    `RCSFD_ASSERT_NXT(a_ch_order, i_clk, i_rst_n, o_ch_valid && i_ch_ready && !o_last_channel, !o_ch_valid || (o_channel_index == $past(o_channel_index) + IDX_W'(1)))

    // reset leaves no result on the output
    `RCSFD_ASSERT_NXT(a_rst_out, i_clk, 1'b1, !i_rst_n, !o_ch_valid)

endmodule

bind rc_serial_frame_decoder_unit rcsfd_checker u_rcsfd_checker (.*);

// ===== tb/tb.sv =====
// testbench for the serial frame decoder: byte driver, channel monitor and self-checking predictor
`timescale 1ns / 1ps

module tb;
    import rcsfd_pkg::*;

    localparam int DRAIN_LIMIT   = 10000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PRINT_LIMIT   = 100;
    localparam int PHASES        = 4;
    localparam int HALF_BUDGET   = 23;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] value;
        logic             last;
    } t_chan_result;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_MIXED} t_fill;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_rx_valid = 1'b0;
    logic                    o_rx_ready;
    logic [7:0]              i_rx_byte = '0;
    logic                    i_cfg_we = 1'b0;
    logic [0:0]              i_cfg_idx = '0;
    logic [CFG_W-1:0]        i_cfg_data = '0;
    logic                    o_ch_valid;
    logic                    i_ch_ready = 1'b0;
    logic [IDX_W-1:0]        o_channel_index;
    logic signed [VAL_W-1:0] o_channel_value;
    logic                    o_last_channel;

    // predictor state
    logic [POS_W-1:0]        rx_position = POS_HUNT;
    logic [7:0]              frame_store [DATA_LEN];
    logic [CFG_W-1:0]        gain = SCALE_FACTOR_RST;
    logic signed [CFG_W-1:0] bias = SCALE_OFFSET_RST;

    logic [7:0]   tx_bytes [$];
    t_chan_result pending_channels [$];
    int           tx_idle_pct = 0;
    int           rx_stall_pct = 0;
    int           mismatch_count = 0;

    rc_serial_frame_decoder_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_valid      (i_rx_valid),
        .o_rx_ready      (o_rx_ready),
        .i_rx_byte       (i_rx_byte),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_ch_valid      (o_ch_valid),
        .i_ch_ready      (i_ch_ready),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_last_channel  (o_last_channel)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("tb: mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    function automatic logic [VAL_W-1:0] scale_raw(input logic [RAW_W-1:0] raw);
        logic [PROD_W-1:0] prod;
        int                sum;
        // round half up before dropping the fraction bits
        prod = PROD_W'(raw) * PROD_W'(gain) + PROD_W'(1 << (FRAC_W - 1));
        sum  = int'(prod[PROD_W-1:FRAC_W]) + int'(bias);
        return sum[VAL_W-1:0];
    endfunction

    function automatic void absorb_rx_byte(input logic [7:0] b);
        t_frame       body;
        t_chan_result r;
        if (rx_position == POS_HUNT) begin
            if (b == HDR_BYTE) begin
                rx_position = POS_W'(1);
            end
        end else if (rx_position <= POS_LAST_D) begin
            frame_store[rx_position - POS_W'(1)] = b;
            rx_position = rx_position + POS_W'(1);
        end else if (rx_position < POS_FOOTER) begin
            // flags byte
            rx_position = rx_position + POS_W'(1);
        end else begin
            rx_position = POS_HUNT;
            if (b == FTR_BYTE) begin
                for (int i = 0; i < DATA_LEN; i++) begin
                    body[i*8 +: 8] = frame_store[i];
                end
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    r.idx   = IDX_W'(ch);
                    r.value = scale_raw(body[ch*RAW_W +: RAW_W]);
                    r.last  = (ch == NUM_CH - 1);
                    pending_channels.push_back(r);
                end
            end
        end
    endfunction

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
        end else if (!i_rx_valid || o_rx_ready) begin
            if (tx_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                i_rx_valid <= 1'b1;
                i_rx_byte  <= tx_bytes.pop_front();
            end else begin
                i_rx_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ch_ready <= 1'b0;
        end else begin
            i_ch_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // monitor: predict on each byte transaction, check each channel transaction
    always @(posedge i_clk) begin : chan_monitor
        t_chan_result want;
        if (i_rst_n) begin
            if (i_rx_valid && o_rx_ready) begin
                absorb_rx_byte(i_rx_byte);
            end
            if (o_ch_valid && i_ch_ready) begin
                if (pending_channels.size() == 0) begin
                    report_mismatch($sformatf("unexpected channel %0d value %0d last %0b",
                        o_channel_index, o_channel_value, o_last_channel));
                end else begin
                    want = pending_channels.pop_front();
                    if (o_channel_index !== want.idx || o_channel_value !== want.value ||
                        o_last_channel !== want.last) begin
                        report_mismatch($sformatf(
                            "got ch %0d val %0d last %0b, want ch %0d val %0d last %0b",
                            o_channel_index, o_channel_value, o_last_channel,
                            want.idx, $signed(want.value), want.last));
                    end
                end
            end
        end
    end

    task automatic write_reg(input t_cfg_reg r, input logic [CFG_W-1:0] d);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= r;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (r == REG_SCALE_FACTOR) begin
            gain = d;
        end else begin
            bias = d;
        end
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        @(negedge i_clk);
        while ((tx_bytes.size() != 0 || i_rx_valid || pending_channels.size() != 0) &&
               n < DRAIN_LIMIT) begin
            @(negedge i_clk);
            n++;
        end
        if (pending_channels.size() != 0) begin
            report_mismatch($sformatf("%0d channel results never arrived",
                pending_channels.size()));
            pending_channels.delete();
        end
        // a frame may still be in flight inside the block
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_frame(input t_fill fill, input logic [7:0] flags,
                               input logic [7:0] footer);
        logic [7:0] b;
        tx_bytes.push_back(HDR_BYTE);
        for (int i = 0; i < DATA_LEN; i++) begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                FILL_MIXED: begin
                    case ($urandom_range(0, 2))
                        0: b = 8'h00;
                        1: b = 8'hFF;
                        default: b = 8'($urandom);
                    endcase
                end
                default: b = 8'($urandom);
            endcase
            tx_bytes.push_back(b);
        end
        tx_bytes.push_back(flags);
        tx_bytes.push_back(footer);
    endtask

    task automatic queue_random(input int budget);
        int         framed;
        int         kind;
        int         n;
        logic [7:0] bad;
        framed = 0;
        while (framed < budget) begin
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                queue_frame(t_fill'($urandom_range(0, 3)), 8'($urandom), FTR_BYTE);
                framed += FRAME_LEN;
            end else if (kind < 80) begin
                bad = $urandom_range(0, 1) ? HDR_BYTE : 8'($urandom_range(1, 255));
                queue_frame(t_fill'($urandom_range(0, 3)), 8'($urandom), bad);
                framed += FRAME_LEN;
            end else if (kind < 90) begin
                // cut-short frame: the next header lands inside this body
                n = $urandom_range(1, 20);
                tx_bytes.push_back(HDR_BYTE);
                repeat (n) tx_bytes.push_back(8'($urandom));
                framed += n + 1;
            end else begin
                // line noise, mostly dropped while hunting
                repeat ($urandom_range(1, 6)) tx_bytes.push_back(8'($urandom));
            end
        end
    endtask

    initial begin
        int tx_idle_tab [PHASES]  = '{0, 52, 0, 17};
        int rx_stall_tab [PHASES] = '{0, 0, 52, 17};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                1: begin
                    write_reg(REG_SCALE_FACTOR, 16'hFFFF);
                    write_reg(REG_SCALE_OFFSET, 16'h7FFF);
                end
                2: begin
                    write_reg(REG_SCALE_FACTOR, 16'h0000);
                    write_reg(REG_SCALE_OFFSET, 16'h8000);
                end
                3: begin
                    write_reg(REG_SCALE_FACTOR, 16'($urandom));
                    write_reg(REG_SCALE_OFFSET, 16'($urandom));
                end
                default: ;
            endcase
            @(negedge i_clk);
            tx_idle_pct  = tx_idle_tab[ph];
            rx_stall_pct = rx_stall_tab[ph];
            if (ph == 0) begin
                // non-header bytes while hunting are dropped
                tx_bytes.push_back(8'hF0);
                tx_bytes.push_back(8'h0E);
                // bad footer equal to the header byte must not start a frame
                queue_frame(FILL_ONES, 8'hFF, HDR_BYTE);
                queue_frame(FILL_ONES, 8'h00, FTR_BYTE);
            end
            queue_random(HALF_BUDGET);
            // sender holds off until every channel has come out
            wait_drained();
            @(negedge i_clk);
            queue_random(HALF_BUDGET);
            wait_drained();
        end
        if (mismatch_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("tb: FAIL");
        $finish;
    end

endmodule
